// ----- rtl/core/sbks_pkg.sv -----
package sbks_pkg;

  // Configuration register indexes, in the order of the register map.
  localparam logic [2:0] CFG_STARTER_INDEX     = 3'd0;
  localparam logic [2:0] CFG_BEAM_MASK         = 3'd1;
  localparam logic [2:0] CFG_BEAM_FADE         = 3'd2;
  localparam logic [2:0] CFG_FADE_SPEED        = 3'd3;
  localparam logic [2:0] CFG_LONG_PRESS_MS     = 3'd4;
  localparam logic [2:0] CFG_DEBOUNCE_MS       = 3'd5;
  localparam logic [2:0] CFG_COOLDOWN_MS       = 3'd6;
  localparam logic [2:0] CFG_SHUTDOWN_DELAY_MS = 3'd7;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [11:0] LONG_PRESS_RESET     = 12'd400;
  localparam logic [7:0]  DEBOUNCE_RESET       = 8'd30;
  localparam logic [11:0] COOLDOWN_RESET       = 12'd200;
  localparam logic [15:0] SHUTDOWN_DELAY_RESET = 16'd10000;

  // Request codes on the action field.
  localparam logic [1:0] ACT_TICK           = 2'd0;
  localparam logic [1:0] ACT_DELAYED_KILL   = 2'd1;
  localparam logic [1:0] ACT_IMMEDIATE_KILL = 2'd2;

  // Blinker commands.
  localparam logic [1:0] BLINK_NONE    = 2'd0;
  localparam logic [1:0] BLINK_SUSPEND = 2'd1;
  localparam logic [1:0] BLINK_RESUME  = 2'd2;

  // Mode commands.
  localparam logic [1:0] MODE_NONE       = 2'd0;
  localparam logic [1:0] MODE_OFF        = 2'd1;
  localparam logic [1:0] MODE_OFF_HAZARD = 2'd2;

  // Timer limits.
  localparam logic [7:0]  DEBOUNCE_MAX = 8'd255;
  localparam logic [15:0] PRESS_MAX    = 16'hFFFF;
  localparam logic [13:0] HAZARD_MAX   = 14'd16383;

  // One hazard blink lasts (255 / 8) * fade_speed * 2 + 200 ticks.
  localparam int unsigned BLINK_STEP = (255 / 8) * 2;
  localparam int unsigned BLINK_BASE = 200;

endpackage

// ----- rtl/core/sbks_if.sv -----
interface sbks_in_if #(
  parameter int unsigned NUM_OUTPUTS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   button_raw;
  logic                   remote_write;
  logic                   remote_value;
  logic [1:0]             action;
  logic                   arm_ok;
  logic [NUM_OUTPUTS-1:0] current_on_mask;
  logic [NUM_OUTPUTS-1:0] beam_lit_mask;

  modport source (
    output valid, button_raw, remote_write, remote_value, action, arm_ok,
           current_on_mask, beam_lit_mask,
    input  ready
  );
  modport sink (
    input  valid, button_raw, remote_write, remote_value, action, arm_ok,
           current_on_mask, beam_lit_mask,
    output ready
  );
endinterface

interface sbks_out_if #(
  parameter int unsigned NUM_OUTPUTS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   drive_update;
  logic [NUM_OUTPUTS-1:0] digital_on_mask;
  logic [NUM_OUTPUTS-1:0] beam_on_mask;
  logic                   beam_immediate;
  logic                   starter_active;
  logic                   shutdown_pending;
  logic [1:0]             blinker_cmd;
  logic [1:0]             mode_cmd;
  logic                   enter_sleep;
  logic                   state_changed;

  modport source (
    output valid, drive_update, digital_on_mask, beam_on_mask, beam_immediate,
           starter_active, shutdown_pending, blinker_cmd, mode_cmd, enter_sleep,
           state_changed,
    input  ready
  );
  modport sink (
    input  valid, drive_update, digital_on_mask, beam_on_mask, beam_immediate,
           starter_active, shutdown_pending, blinker_cmd, mode_cmd, enter_sleep,
           state_changed,
    output ready
  );
endinterface

// ----- rtl/core/starter_button_and_kill_sequencer.sv -----
// Starter button and kill sequencer.
// Each beat on in_bus is one millisecond tick: raw button level, remote press
// latch write, kill request, arm grant and the present output and beam states.
// Each accepted tick produces exactly one beat on out_bus with the drive
// commands, blinker and mode commands, sleep request and status flags.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while the block is idle (the block does not enforce this).
// Every 3-bit cfg_index value names a register. An input beat waits in the
// input register, then the tick logic runs and its state update and result are
// registered together. One tick is accepted every cycle while the receiver does
// not stall; the rate is set by the single pass through the tick logic, which
// carries the state of one tick to the next in the same cycle.
// If the receiver stalls, the result stays in the output register and one more
// tick is held in the input register; in_bus.ready drops only when both are full.
// Reset (synchronous, rst_n low) clears all timers, latches and the kill
// sequence, restores register defaults and empties both pipeline registers.
module starter_button_and_kill_sequencer
  import sbks_pkg::*;
#(
  parameter int unsigned NUM_OUTPUTS  = 10,
  parameter int unsigned MIN_SHORT_MS = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  sbks_in_if.sink                in_bus,
  sbks_out_if.source             out_bus,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned N = NUM_OUTPUTS;

  typedef enum logic [1:0] {
    KP_COUNT,
    KP_OFF,
    KP_HAZARD
  } kill_phase_t;

  // Configuration registers.
  logic [3:0]   starter_index_r;
  logic [N-1:0] beam_mask_r;
  logic         beam_fade_r;
  logic [7:0]   fade_speed_r;
  logic [11:0]  long_press_ms_r;
  logic [7:0]   debounce_ms_r;
  logic [11:0]  cooldown_ms_r;
  logic [15:0]  shutdown_delay_ms_r;

  // Input stage.
  logic         s1_valid_r;
  logic         s1_btn_r, s1_rw_r, s1_rv_r, s1_arm_r;
  logic [1:0]   s1_action_r;
  logic [N-1:0] s1_cur_r, s1_lit_r;
  logic         s1_advance;

  // Tick state.
  logic         raw_level_r, raw_level_nxt;
  logic [7:0]   debounce_timer_r, debounce_timer_nxt;
  logic         debounced_r, debounced_nxt;
  logic         remote_latch_r, remote_latch_nxt;
  logic         prev_active_r, prev_active_nxt;
  logic         press_valid_r, press_valid_nxt;
  logic [15:0]  press_timer_r, press_timer_nxt;
  logic         long_done_r, long_done_nxt;
  logic [11:0]  cooldown_timer_r, cooldown_timer_nxt;
  logic         starter_on_r, starter_on_nxt;
  logic [N-1:0] saved_digital_r, saved_digital_nxt;
  logic [N-1:0] saved_beam_r, saved_beam_nxt;
  logic         kill_pending_r, kill_pending_nxt;
  logic [15:0]  kill_countdown_r, kill_countdown_nxt;
  kill_phase_t  kill_phase_r, kill_phase_nxt;
  logic [13:0]  hazard_timer_r, hazard_timer_nxt;

  // Result register.
  logic         out_valid_r;
  logic         drive_r, drive_nxt;
  logic [N-1:0] dig_r, dig_nxt;
  logic [N-1:0] beam_r, beam_nxt;
  logic         imm_r, imm_nxt;
  logic [1:0]   blink_r, blink_nxt;
  logic [1:0]   mode_r, mode_nxt;
  logic         sleep_r, sleep_nxt;
  logic         changed_r, changed_nxt;

  // Derived masks and limits.
  logic [N-1:0] starter_bit;
  logic [N-1:0] beams_other;
  logic [N-1:0] plain_other;
  logic [13:0]  blink_len;

  logic         active, rise, fall, in_cooldown;
  logic         button_kill, kill_req;
  logic [15:0]  kill_delay;

  assign s1_advance   = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_advance;

  always_comb begin
    starter_bit = '0;
    if (32'(starter_index_r) < N) begin
      starter_bit = N'(1) << starter_index_r;
    end
  end

  assign beams_other = beam_mask_r & ~starter_bit;
  assign plain_other = ~beams_other & ~starter_bit;
  assign blink_len   = 14'(fade_speed_r * 14'(BLINK_STEP)) + 14'(BLINK_BASE);

  always_comb begin
    raw_level_nxt      = raw_level_r;
    debounce_timer_nxt = debounce_timer_r;
    debounced_nxt      = debounced_r;
    remote_latch_nxt   = remote_latch_r;
    prev_active_nxt    = prev_active_r;
    press_valid_nxt    = press_valid_r;
    press_timer_nxt    = press_timer_r;
    long_done_nxt      = long_done_r;
    cooldown_timer_nxt = cooldown_timer_r;
    starter_on_nxt     = starter_on_r;
    saved_digital_nxt  = saved_digital_r;
    saved_beam_nxt     = saved_beam_r;
    kill_pending_nxt   = kill_pending_r;
    kill_countdown_nxt = kill_countdown_r;
    kill_phase_nxt     = kill_phase_r;
    hazard_timer_nxt   = hazard_timer_r;
    drive_nxt          = 1'b0;
    dig_nxt            = '0;
    beam_nxt           = '0;
    imm_nxt            = 1'b0;
    blink_nxt          = BLINK_NONE;
    mode_nxt           = MODE_NONE;
    sleep_nxt          = 1'b0;
    changed_nxt        = 1'b0;
    button_kill        = 1'b0;

    if (s1_rw_r) begin
      remote_latch_nxt = s1_rv_r;
    end

    // Debounce: the level follows once the raw input has been stable long enough.
    if (s1_btn_r != raw_level_r) begin
      raw_level_nxt      = s1_btn_r;
      debounce_timer_nxt = '0;
    end else if (debounce_timer_r != DEBOUNCE_MAX) begin
      debounce_timer_nxt = debounce_timer_r + 8'd1;
    end
    if (debounce_timer_nxt >= debounce_ms_r) begin
      debounced_nxt = raw_level_nxt;
    end

    active          = debounced_nxt | remote_latch_nxt;
    rise            = active & ~prev_active_r;
    fall            = ~active & prev_active_r;
    prev_active_nxt = active;

    if (press_valid_r && press_timer_r != PRESS_MAX) begin
      press_timer_nxt = press_timer_r + 16'd1;
    end

    // A tick that leaves the cooldown still running skips all press handling.
    in_cooldown = 1'b0;
    if (cooldown_timer_r != '0) begin
      cooldown_timer_nxt = cooldown_timer_r - 12'd1;
      in_cooldown        = (cooldown_timer_nxt != '0);
    end

    if (!in_cooldown) begin
      if (rise) begin
        press_valid_nxt = 1'b1;
        press_timer_nxt = '0;
        long_done_nxt   = 1'b0;
      end
      if (active && !long_done_nxt && press_valid_nxt &&
          press_timer_nxt > {4'd0, long_press_ms_r}) begin
        long_done_nxt    = 1'b1;
        kill_pending_nxt = 1'b0;
        if (s1_arm_r && !starter_on_nxt) begin
          starter_on_nxt    = 1'b1;
          saved_beam_nxt    = s1_lit_r & beams_other;
          saved_digital_nxt = s1_cur_r & plain_other;
          drive_nxt         = 1'b1;
          dig_nxt           = starter_bit | (s1_cur_r & beams_other);
          beam_nxt          = '0;
          imm_nxt           = 1'b1;
          blink_nxt         = BLINK_SUSPEND;
          changed_nxt       = 1'b1;
        end
      end
      if (fall) begin
        if (long_done_nxt) begin
          if (starter_on_nxt) begin
            starter_on_nxt = 1'b0;
            drive_nxt      = 1'b1;
            dig_nxt        = (saved_digital_nxt & plain_other) | (s1_cur_r & beams_other);
            beam_nxt       = saved_beam_nxt & beams_other;
            imm_nxt        = ~beam_fade_r;
            blink_nxt      = BLINK_RESUME;
            changed_nxt    = 1'b1;
          end
          cooldown_timer_nxt = cooldown_ms_r;
        end else if (press_valid_nxt && press_timer_nxt >= 16'(MIN_SHORT_MS) &&
                     press_timer_nxt <= {4'd0, long_press_ms_r}) begin
          button_kill = 1'b1;
        end
        press_valid_nxt  = 1'b0;
        long_done_nxt    = 1'b0;
        remote_latch_nxt = 1'b0;
      end
    end

    // A short press takes precedence over a request in the same tick; both
    // are ignored while a kill is already pending.
    kill_req   = button_kill || (s1_action_r == ACT_DELAYED_KILL) ||
                 (s1_action_r == ACT_IMMEDIATE_KILL);
    kill_delay = (button_kill || s1_action_r == ACT_DELAYED_KILL) ?
                 shutdown_delay_ms_r : '0;
    if (kill_req && !kill_pending_nxt) begin
      if (starter_on_nxt) begin
        starter_on_nxt = 1'b0;
        drive_nxt      = 1'b1;
        dig_nxt        = (saved_digital_nxt & plain_other) | (s1_cur_r & beams_other);
        beam_nxt       = saved_beam_nxt & beams_other;
        imm_nxt        = ~beam_fade_r;
        blink_nxt      = BLINK_RESUME;
        changed_nxt    = 1'b1;
      end
      kill_pending_nxt   = 1'b1;
      kill_countdown_nxt = kill_delay;
      kill_phase_nxt     = KP_COUNT;
    end

    if (kill_pending_nxt) begin
      if (kill_countdown_nxt != '0) begin
        kill_countdown_nxt = kill_countdown_nxt - 16'd1;
        kill_phase_nxt     = KP_COUNT;
      end else begin
        case (kill_phase_nxt)
          KP_COUNT: begin
            drive_nxt      = 1'b1;
            dig_nxt        = '0;
            beam_nxt       = '0;
            imm_nxt        = 1'b1;
            blink_nxt      = BLINK_SUSPEND;
            kill_phase_nxt = KP_OFF;
          end
          KP_OFF: begin
            mode_nxt         = MODE_OFF_HAZARD;
            kill_phase_nxt   = KP_HAZARD;
            hazard_timer_nxt = '0;
          end
          KP_HAZARD: begin
            if (hazard_timer_nxt != HAZARD_MAX) begin
              hazard_timer_nxt = hazard_timer_nxt + 14'd1;
            end
            if (hazard_timer_nxt >= blink_len) begin
              mode_nxt         = MODE_OFF;
              sleep_nxt        = 1'b1;
              kill_phase_nxt   = KP_COUNT;
              kill_pending_nxt = 1'b0;
            end
          end
          default: begin
            kill_phase_nxt = KP_COUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      starter_index_r     <= '0;
      beam_mask_r         <= '0;
      beam_fade_r         <= 1'b0;
      fade_speed_r        <= '0;
      long_press_ms_r     <= LONG_PRESS_RESET;
      debounce_ms_r       <= DEBOUNCE_RESET;
      cooldown_ms_r       <= COOLDOWN_RESET;
      shutdown_delay_ms_r <= SHUTDOWN_DELAY_RESET;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      raw_level_r         <= 1'b0;
      debounce_timer_r    <= '0;
      debounced_r         <= 1'b0;
      remote_latch_r      <= 1'b0;
      prev_active_r       <= 1'b0;
      press_valid_r       <= 1'b0;
      press_timer_r       <= '0;
      long_done_r         <= 1'b0;
      cooldown_timer_r    <= '0;
      starter_on_r        <= 1'b0;
      saved_digital_r     <= '0;
      saved_beam_r        <= '0;
      kill_pending_r      <= 1'b0;
      kill_countdown_r    <= '0;
      kill_phase_r        <= KP_COUNT;
      hazard_timer_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STARTER_INDEX:     starter_index_r     <= cfg_wdata[3:0];
          CFG_BEAM_MASK:         beam_mask_r         <= cfg_wdata[N-1:0];
          CFG_BEAM_FADE:         beam_fade_r         <= cfg_wdata[0];
          CFG_FADE_SPEED:        fade_speed_r        <= cfg_wdata[7:0];
          CFG_LONG_PRESS_MS:     long_press_ms_r     <= cfg_wdata[11:0];
          CFG_DEBOUNCE_MS:       debounce_ms_r       <= cfg_wdata[7:0];
          CFG_COOLDOWN_MS:       cooldown_ms_r       <= cfg_wdata[11:0];
          CFG_SHUTDOWN_DELAY_MS: shutdown_delay_ms_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end

      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end

      if (s1_advance) begin
        raw_level_r      <= raw_level_nxt;
        debounce_timer_r <= debounce_timer_nxt;
        debounced_r      <= debounced_nxt;
        remote_latch_r   <= remote_latch_nxt;
        prev_active_r    <= prev_active_nxt;
        press_valid_r    <= press_valid_nxt;
        press_timer_r    <= press_timer_nxt;
        long_done_r      <= long_done_nxt;
        cooldown_timer_r <= cooldown_timer_nxt;
        starter_on_r     <= starter_on_nxt;
        saved_digital_r  <= saved_digital_nxt;
        saved_beam_r     <= saved_beam_nxt;
        kill_pending_r   <= kill_pending_nxt;
        kill_countdown_r <= kill_countdown_nxt;
        kill_phase_r     <= kill_phase_nxt;
        hazard_timer_r   <= hazard_timer_nxt;
      end
    end

    // Payload registers.
    if (in_bus.valid && in_bus.ready) begin
      s1_btn_r    <= in_bus.button_raw;
      s1_rw_r     <= in_bus.remote_write;
      s1_rv_r     <= in_bus.remote_value;
      s1_action_r <= in_bus.action;
      s1_arm_r    <= in_bus.arm_ok;
      s1_cur_r    <= in_bus.current_on_mask;
      s1_lit_r    <= in_bus.beam_lit_mask;
    end
    if (s1_advance) begin
      drive_r   <= drive_nxt;
      dig_r     <= dig_nxt;
      beam_r    <= beam_nxt;
      imm_r     <= imm_nxt;
      blink_r   <= blink_nxt;
      mode_r    <= mode_nxt;
      sleep_r   <= sleep_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.drive_update     = drive_r;
  assign out_bus.digital_on_mask  = dig_r;
  assign out_bus.beam_on_mask     = beam_r;
  assign out_bus.beam_immediate   = imm_r;
  assign out_bus.starter_active   = starter_on_r;
  assign out_bus.shutdown_pending = kill_pending_r;
  assign out_bus.blinker_cmd      = blink_r;
  assign out_bus.mode_cmd         = mode_r;
  assign out_bus.enter_sleep      = sleep_r;
  assign out_bus.state_changed    = changed_r;

endmodule
